// ===== rtl/core/ppg_pkg.sv =====
// plasma pattern generator: shared widths, multiplier constants and the quarter-wave sine table
// no dependencies; every other file of the block refers to this package by scoped names
`default_nettype none

package ppg_pkg;

	localparam int COORD_BITS      = 10;
	localparam int SINE_INDEX_BITS = 12;

	// angles are turns with 16 fraction bits
	localparam int PHASE_W = 16;

	// x/d in turns is (coord * K) >> 8, K = round(2^24 / (2*pi*d))
	localparam int LIN_W = PHASE_W + 8;
	localparam logic [19:0] K_DIV7 = 20'd381454;
	localparam logic [19:0] K_DIV5 = 20'd534035;
	localparam logic [19:0] K_DIV6 = 20'd445029;
	localparam logic [19:0] K_DIV4 = 20'd667544;
	localparam int ROOT_PROD_W = 32;

	// root of (x*x + y*y) << 16, one result bit per pipeline stage
	localparam int SQ_W        = 2 * COORD_BITS;
	localparam int SUMSQ_W     = SQ_W + 1;
	localparam int RAD_W       = SUMSQ_W + 16;
	localparam int ROOT_W      = (RAD_W + 1) / 2;
	localparam int ROOT_STAGES = ROOT_W;

	// two input stages, root stages, root product, angle, three sine stages
	localparam int PIPE_STAGES = ROOT_STAGES + 7;

	// quarter-wave table, split into banks of at most 256 rows
	localparam int QUARTER_BITS = SINE_INDEX_BITS - 2;
	localparam int QUARTER_SIZE = 1 << QUARTER_BITS;
	localparam int QIDX_W       = QUARTER_BITS + 1;
	localparam int ROW_BITS     = (QUARTER_BITS > 8) ? 8 : QUARTER_BITS;
	localparam int BANK_BITS    = QUARTER_BITS - ROW_BITS;
	localparam int NUM_BANKS    = 1 << BANK_BITS;
	localparam int ROWS         = 1 << ROW_BITS;
	localparam int BSEL_W       = (BANK_BITS > 0) ? BANK_BITS : 1;
	localparam int SINE_W       = 15;

	// 127 + 127*sin with 14 fraction bits, and the sum of four of them
	localparam int WAVE_BASE_W = 16;
	localparam logic [WAVE_BASE_W-1:0] ONE_Q14 = 16'd16384;
	localparam int TERM_W   = 22;
	localparam int SUM_W    = 24;
	localparam int LEVEL_W  = 8;
	localparam int NUM_WAVES = 4;

	localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;
	localparam int SERIES_TERMS = 19;
	localparam int unsigned SERIES_DIV [SERIES_TERMS] = '{
		6, 20, 42, 72, 110, 156, 210, 272, 342, 420,
		506, 600, 702, 812, 930, 1056, 1190, 1332, 1482
	};

	typedef logic [SINE_W-1:0] qsine_rom_t [QUARTER_SIZE+1];

	typedef struct packed {
		logic [PHASE_W-1:0] x_ang;
		logic [PHASE_W-1:0] y_ang;
		logic [PHASE_W-1:0] d_ang;
	} lin_angles_t;

	// (a * b) >> 62 over the full 128-bit product
	function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[125:62];
	endfunction

	// round(2^14 * sin(pi/2 * j / QUARTER_SIZE)) from a Taylor series in Q62
	function automatic logic [SINE_W-1:0] quarter_sine(input int unsigned j);
		logic [63:0] step_v;
		logic [63:0] th;
		logic [63:0] th2;
		logic [63:0] term;
		logic [63:0] acc;
		logic [63:0] rounded;
		step_v = HALF_PI_Q62 >> QUARTER_BITS;
		th     = step_v * 64'(j);
		th2    = mul_q62(th, th);
		term   = th;
		acc    = th;
		for (int k = 0; k < SERIES_TERMS; k++) begin
			term = mul_q62(term, th2) / 64'(SERIES_DIV[k]);
			if ((k & 1) == 0) begin
				acc = acc - term;
			end else begin
				acc = acc + term;
			end
		end
		rounded = (acc + (64'd1 << 47)) >> 48;
		return rounded[SINE_W-1:0];
	endfunction

	function automatic qsine_rom_t build_qsine();
		qsine_rom_t rom;
		for (int j = 0; j <= QUARTER_SIZE; j++) begin
			rom[j] = quarter_sine(j);
		end
		return rom;
	endfunction

	localparam qsine_rom_t QSINE = build_qsine();
	localparam logic [SINE_W-1:0] SINE_PEAK = QSINE[QUARTER_SIZE];

endpackage

`default_nettype wire

// ===== rtl/core/ppg_pixel_if.sv =====
// pixel coordinate channel: valid/ready with pixel_x and pixel_y
// widths come from ppg_pkg
`default_nettype none

interface ppg_pixel_if;
	logic                           valid;
	logic                           ready;
	logic [ppg_pkg::COORD_BITS-1:0] pixel_x;
	logic [ppg_pkg::COORD_BITS-1:0] pixel_y;

	modport source (output valid, output pixel_x, output pixel_y, input ready);
	modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ppg_gray_if.sv =====
// gray level channel: valid/ready with gray_level
// widths come from ppg_pkg
`default_nettype none

interface ppg_gray_if;
	logic                        valid;
	logic                        ready;
	logic [ppg_pkg::LEVEL_W-1:0] gray_level;

	modport source (output valid, output gray_level, input ready);
	modport sink (input valid, input gray_level, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/plasma_pattern_generator.sv =====
// plasma pattern generator: one gray level per pixel coordinate
//
// coord carries (pixel_x, pixel_y) requests, level returns one gray_level (0..254) per
// request, in order. cfg_we/cfg_wdata write the animation phase time_phase; write it
// only while no request is in flight.
// Throughput: one request per clock with level.ready high; pixels are independent.
// Pipeline: a request runs through two input stages, the square root pipeline (one root
// bit per stage), a root multiply, an angle stage and three sine table stages; the result
// then goes into the output register, which drives level.valid.
// Stall: results wait in an output register backed by one skid entry. The request behind
// a waiting result is still taken; the pipeline then freezes with coord.ready low until
// level.ready returns. Nothing is dropped or repeated.
// Reset: arst_n clears all valid bits and sets time_phase to 0. There is no table fill
// after reset; the sine table is constant logic.
// Depends on ppg_pkg, ppg_pixel_if, ppg_gray_if, ppg_isqrt, ppg_wave_term, ppg_out_skid.
`default_nettype none

module plasma_pattern_generator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ppg_pkg::PHASE_W-1:0]   cfg_wdata,
	ppg_pixel_if.sink                     coord,
	ppg_gray_if.source                    level
);

	localparam int N  = ppg_pkg::PIPE_STAGES;
	localparam int RS = ppg_pkg::ROOT_STAGES;
	localparam int PW = ppg_pkg::PHASE_W;
	localparam int LW = ppg_pkg::LIN_W;

	logic                 en;
	logic [N-1:0]         vld_s;
	logic [PW-1:0]        time_phase_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_phase_q <= '0;
		end else if (cfg_we) begin
			time_phase_q <= cfg_wdata;
		end
	end

	// valid bits move with the data; the whole line holds while the skid is full
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[N-2:0], coord.valid};
		end
	end

	assign coord.ready = en;

	// stage 1: squares and the three linear angles
	logic [LW-1:0] prod_x;
	logic [LW-1:0] prod_y;
	logic [LW-1:0] prod_d;

	assign prod_x = LW'(coord.pixel_x) * LW'(ppg_pkg::K_DIV7);
	assign prod_y = LW'(coord.pixel_y) * LW'(ppg_pkg::K_DIV5);
	assign prod_d = (LW'(coord.pixel_x) + LW'(coord.pixel_y)) * LW'(ppg_pkg::K_DIV6);

	logic [ppg_pkg::SQ_W-1:0] sqx_s1;
	logic [ppg_pkg::SQ_W-1:0] sqy_s1;
	ppg_pkg::lin_angles_t     lin_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s1       <= ppg_pkg::SQ_W'(coord.pixel_x) * ppg_pkg::SQ_W'(coord.pixel_x);
			sqy_s1       <= ppg_pkg::SQ_W'(coord.pixel_y) * ppg_pkg::SQ_W'(coord.pixel_y);
			lin_s1.x_ang <= prod_x[LW-1:8];
			lin_s1.y_ang <= prod_y[LW-1:8];
			lin_s1.d_ang <= prod_d[LW-1:8];
		end
	end

	// stage 2: sum of squares
	logic [ppg_pkg::SUMSQ_W-1:0] sumsq_s2;
	ppg_pkg::lin_angles_t        lin_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			sumsq_s2 <= ppg_pkg::SUMSQ_W'(sqx_s1) + ppg_pkg::SUMSQ_W'(sqy_s1);
			lin_s2   <= lin_s1;
		end
	end

	// root stages, linear angles ride alongside
	logic [ppg_pkg::ROOT_W-1:0] root;
	ppg_pkg::lin_angles_t       lin_dly_s [RS];

	ppg_isqrt u_isqrt (
		.clk      (clk),
		.en       (en),
		.radicand ({sumsq_s2, 16'd0}),
		.root     (root)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			lin_dly_s[0] <= lin_s2;
			for (int k = 1; k < RS; k++) begin
				lin_dly_s[k] <= lin_dly_s[k-1];
			end
		end
	end

	// stages after the root: radial product, then the four phased angles
	logic [ppg_pkg::ROOT_PROD_W-1:0] prod4_sr1;
	ppg_pkg::lin_angles_t            lin_sr1;
	logic [PW-1:0]                   ang_sr2 [ppg_pkg::NUM_WAVES];

	always_ff @(posedge clk) begin
		if (en) begin
			prod4_sr1 <= ppg_pkg::ROOT_PROD_W'(root) * ppg_pkg::ROOT_PROD_W'(ppg_pkg::K_DIV4);
			lin_sr1   <= lin_dly_s[RS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ang_sr2[0] <= lin_sr1.x_ang + time_phase_q;
			ang_sr2[1] <= lin_sr1.y_ang - time_phase_q;
			ang_sr2[2] <= lin_sr1.d_ang - time_phase_q;
			ang_sr2[3] <= prod4_sr1[ppg_pkg::ROOT_PROD_W-1 -: PW] - time_phase_q;
		end
	end

	logic [ppg_pkg::TERM_W-1:0] term_w [ppg_pkg::NUM_WAVES];

	for (genvar i = 0; i < ppg_pkg::NUM_WAVES; i++) begin : g_wave
		ppg_wave_term u_wave (
			.clk   (clk),
			.en    (en),
			.angle (ang_sr2[i]),
			.term  (term_w[i])
		);
	end

	// drop the 14 fraction bits and divide by four
	logic [ppg_pkg::SUM_W-1:0]   total;
	logic [ppg_pkg::LEVEL_W-1:0] push_level;

	assign total = ppg_pkg::SUM_W'(term_w[0]) + ppg_pkg::SUM_W'(term_w[1])
		+ ppg_pkg::SUM_W'(term_w[2]) + ppg_pkg::SUM_W'(term_w[3]);
	assign push_level = total[ppg_pkg::SUM_W-1 -: ppg_pkg::LEVEL_W];

	ppg_out_skid u_out_skid (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (vld_s[N-1]),
		.push_level (push_level),
		.take       (en),
		.gray       (level)
	);

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		level.valid |-> (level.gray_level <= 8'd254))
		else $error("gray level above 254");

	a_stall_only_on_held_result: assert property (@(posedge clk) disable iff (!arst_n)
		!coord.ready |-> level.valid)
		else $error("input held off with no result waiting");

endmodule

`default_nettype wire

// ===== rtl/core/ppg_isqrt.sv =====
// pipelined integer square root, one result bit resolved per stage
// uses ppg_pkg widths; stalls with the rest of the pipeline through en
`default_nettype none

module ppg_isqrt (
	input  logic                        clk,
	input  logic                        en,
	input  logic [ppg_pkg::RAD_W-1:0]   radicand,
	output logic [ppg_pkg::ROOT_W-1:0]  root
);

	localparam int RW   = ppg_pkg::ROOT_W;
	localparam int RM_W = RW + 2;
	localparam int D_W  = 2 * RW;

	logic [RM_W-1:0] rem_s [RW];
	logic [RW-1:0]   q_s   [RW];
	logic [D_W-1:0]  d_s   [RW];

	for (genvar k = 0; k < RW; k++) begin : g_bit
		logic [RM_W-1:0] rem_in;
		logic [RW-1:0]   q_in;
		logic [D_W-1:0]  d_in;
		logic [RM_W-1:0] shifted;
		logic [RM_W-1:0] trial;

		if (k == 0) begin : g_first
			assign rem_in = '0;
			assign q_in   = '0;
			assign d_in   = D_W'(radicand);
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign q_in   = q_s[k-1];
			assign d_in   = d_s[k-1];
		end

		// bring down the next two radicand bits, try (4q + 1)
		assign shifted = {rem_in[RM_W-3:0], d_in[D_W-1 -: 2]};
		assign trial   = {q_in, 2'b01};

		always_ff @(posedge clk) begin
			if (en) begin
				if (shifted >= trial) begin
					rem_s[k] <= shifted - trial;
					q_s[k]   <= {q_in[RW-2:0], 1'b1};
				end else begin
					rem_s[k] <= shifted;
					q_s[k]   <= {q_in[RW-2:0], 1'b0};
				end
				d_s[k] <= d_in << 2;
			end
		end
	end

	assign root = q_s[RW-1];

endmodule

`default_nettype wire

// ===== rtl/core/ppg_wave_term.sv =====
// one wave term 127 + 127*sin(angle) in three stages: fold, bank read, select and scale
// uses the quarter-wave table and widths of ppg_pkg
`default_nettype none

module ppg_wave_term (
	input  logic                         clk,
	input  logic                         en,
	input  logic [ppg_pkg::PHASE_W-1:0]  angle,
	output logic [ppg_pkg::TERM_W-1:0]   term
);

	localparam int SIB = ppg_pkg::SINE_INDEX_BITS;
	localparam int QB  = ppg_pkg::QUARTER_BITS;
	localparam int RB  = ppg_pkg::ROW_BITS;
	localparam int BW  = ppg_pkg::BSEL_W;
	localparam int NB  = ppg_pkg::NUM_BANKS;

	logic [SIB-1:0] idx;
	logic [1:0]     quad;
	logic [QB-1:0]  jraw;
	logic [QB-1:0]  jfold;
	logic           peak;

	assign idx   = angle[ppg_pkg::PHASE_W-1 -: SIB];
	assign quad  = idx[SIB-1 -: 2];
	assign jraw  = idx[QB-1:0];
	// second and fourth quarters run the table backwards; j = 0 there is the crest
	assign jfold = quad[0] ? (~jraw + QB'(1)) : jraw;
	assign peak  = quad[0] && (jraw == '0);

	logic [RB-1:0] row_s1;
	logic [BW-1:0] bsel_s1;
	logic          peak_s1;
	logic          neg_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			row_s1  <= RB'(jfold);
			bsel_s1 <= BW'(jfold >> RB);
			peak_s1 <= peak;
			neg_s1  <= quad[1];
		end
	end

	logic [ppg_pkg::SINE_W-1:0] bank_s2 [NB];
	logic [BW-1:0]              bsel_s2;
	logic                       peak_s2;
	logic                       neg_s2;

	for (genvar b = 0; b < NB; b++) begin : g_bank
		always_ff @(posedge clk) begin
			if (en) begin
				bank_s2[b] <= ppg_pkg::QSINE[ppg_pkg::QIDX_W'(b * ppg_pkg::ROWS) +
					ppg_pkg::QIDX_W'(row_s1)];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bsel_s2 <= bsel_s1;
			peak_s2 <= peak_s1;
			neg_s2  <= neg_s1;
		end
	end

	logic [ppg_pkg::SINE_W-1:0]      mag;
	logic [ppg_pkg::WAVE_BASE_W-1:0] wave_base;
	logic [ppg_pkg::TERM_W-1:0]      term_s3;

	assign mag       = peak_s2 ? ppg_pkg::SINE_PEAK : bank_s2[bsel_s2];
	assign wave_base = neg_s2 ? (ppg_pkg::ONE_Q14 - ppg_pkg::WAVE_BASE_W'(mag))
		: (ppg_pkg::ONE_Q14 + ppg_pkg::WAVE_BASE_W'(mag));

	// times 127 as shift and subtract
	always_ff @(posedge clk) begin
		if (en) begin
			term_s3 <= (ppg_pkg::TERM_W'(wave_base) << 7) - ppg_pkg::TERM_W'(wave_base);
		end
	end

	assign term = term_s3;

endmodule

`default_nettype wire

// ===== rtl/core/ppg_out_skid.sv =====
// output register with one skid entry; takes a result while the one in front waits
// uses ppg_pkg and the ppg_gray_if channel
`default_nettype none

module ppg_out_skid (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push_valid,
	input  logic [ppg_pkg::LEVEL_W-1:0]  push_level,
	output logic                         take,
	ppg_gray_if.source                   gray
);

	logic                        out_valid_q;
	logic [ppg_pkg::LEVEL_W-1:0] out_data_q;
	logic                        skid_valid_q;
	logic [ppg_pkg::LEVEL_W-1:0] skid_data_q;
	logic                        pop;
	logic                        push;

	assign take = !skid_valid_q;
	assign pop  = out_valid_q && gray.ready;
	assign push = push_valid && take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_data_q <= skid_data_q;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				skid_data_q <= push_level;
			end else begin
				out_data_q <= push_level;
			end
		end
	end

	assign gray.valid      = out_valid_q;
	assign gray.gray_level = out_data_q;

	// skid only fills behind a waiting result
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held with output register empty");

	a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && !gray.ready))
		else $error("skid filled without a stalled output");

endmodule

`default_nettype wire
